FILE: rtl/core/ps2cps_pkg.sv
// Shared types, constants and codes of the PS/2 command packet sender.
package ps2cps_pkg;

    // Default packet store depth
    localparam int MAX_PACKET_BYTES_DEF = 16;

    // Command queue between front and back end (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int M_FIELD_W = 14;

    // Field widths
    localparam int IDX_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 3;

    // Item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_REPLY = 2'd2;

    // Device reply bytes and controller prefix
    localparam logic [7:0] REPLY_RESEND = 8'hFE;
    localparam logic [7:0] REPLY_NACK   = 8'hFC;
    localparam logic [7:0] PREFIX_MOUSE = 8'hD4;

    // Status codes
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_SUCCESS = 3'd1;
    localparam logic [2:0] ST_BUSY    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;

    // Reset value of the resend limit
    localparam logic [7:0] RESEND_LIMIT_RST = 8'd3;

    // One classified command handed from front to back end
    typedef struct packed {
        logic                send;
        logic                mouse;
        logic                handled;
        logic                finished;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    // Queue entry: command plus the packet byte fetched for it
    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] data;
    } t_qentry;

endpackage

FILE: rtl/core/ps2_command_packet_sender.sv
// Top level of the PS/2 command packet sender.
// Sends a command packet to a keyboard or mouse through an i8042-style
// controller. Load items (tuser 0) fill the packet store, a start item
// (tuser 1) writes byte 0, and each device reply byte (tuser 2) moves the
// packet on: RESEND repeats the previous byte up to resend_limit times in a
// row, NACK fails it, anything else sends the next byte or ends with success.
// Mouse bytes go out behind a 0xD4 prefix on the control port. Each item
// produces zero to three results; the last result of an item carries tlast.
// Rate: the input takes one item per cycle while the four-entry command
// queue has room; the back end sends one result per cycle while the output
// stream takes them, so an item needs one output slot for a status only, two
// for a keyboard write and three for a mouse write, and the output stream
// sets the sustained rate. An item reaches the output through the store read,
// the queue, the back-end command register and the output register. No clearing
// pass after reset; the store holds whatever was last loaded.
module ps2_command_packet_sender #(
    parameter int MAX_PACKET_BYTES = ps2cps_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ps2cps_pkg::S_TUSER_W-1:0] i_s_tuser,  // [1:0] mode
    // [3:0] byte_index, [11:4] byte_value, [16:12] byte_count,
    // [17] to_mouse, [18] port_ready, [23:19] zero
    input  logic [ps2cps_pkg::S_TDATA_W-1:0] i_s_tdata,
    // Result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] to_control_port, [8:1] write_value, [9] handled, [10] finished,
    // [13:11] status, [15:14] zero
    output logic [ps2cps_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tuser,  // [0] kind
    output logic                             o_m_tlast,  // last result of the item
    // Resend limit write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ps2cps_pkg::BYTE_W-1:0]    i_cfg_data
);
    import ps2cps_pkg::*;

    logic                q_push;
    t_qentry             q_in;
    t_qentry             q_out;
    logic                q_pop;
    logic                q_empty;
    logic [QUEUE_CW-1:0] q_count;

    // The limit register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    ps2cps_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_entry   (q_in)
    );

    ps2cps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    ps2cps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_entry  (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: rtl/core/ps2cps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ps2cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ps2cps_front.sv
// Front end: accepts items, runs the packet state, fetches bytes, feeds the queue.
module ps2cps_front #(
    parameter int MAX_PACKET_BYTES = ps2cps_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ps2cps_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic [ps2cps_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                             i_cfg_valid,
    input  logic [ps2cps_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic [ps2cps_pkg::QUEUE_CW-1:0]  i_q_count,
    output logic                             o_q_push,
    output ps2cps_pkg::t_qentry              o_q_entry
);
    import ps2cps_pkg::*;

    localparam int AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

    // Unpacked input fields
    logic [1:0]        f_mode;
    logic [IDX_W-1:0]  f_idx;
    logic [BYTE_W-1:0] f_val;
    logic [CNT_W-1:0]  f_cnt;
    logic              f_mouse;
    logic              f_ready;

    assign f_mode  = i_s_tuser;
    assign f_idx   = i_s_tdata[3:0];
    assign f_val   = i_s_tdata[11:4];
    assign f_cnt   = i_s_tdata[16:12];
    assign f_mouse = i_s_tdata[17];
    assign f_ready = i_s_tdata[18];

    // Packet state
    logic              r_sending, n_sending;
    logic [CNT_W-1:0]  r_next_index, n_next_index;
    logic [CNT_W-1:0]  r_send_length, n_send_length;
    logic [BYTE_W-1:0] r_retry_count, n_retry_count;
    logic              r_mouse_target, n_mouse_target;
    logic [BYTE_W-1:0] r_resend_limit;

    // Stage between decode and queue push, waiting on the store read
    logic r_s1_valid;
    t_cmd r_s1_cmd;

    logic              accept;
    logic              cmd_push;
    t_cmd              cmd;
    logic [CNT_W-1:0]  rd_idx;
    logic              ram_we;
    logic [CNT_W-1:0]  idx_v;
    logic [BYTE_W-1:0] retry_v;
    logic              stop_v;

    logic [AW+CNT_W-1:0] rd_wide;
    logic [AW+IDX_W-1:0] wr_wide;
    logic [BYTE_W-1:0]   ram_rdata;

    // Accept only with room for this item and the one still in the fetch stage
    assign o_s_tready = (int'(i_q_count) + int'(r_s1_valid)) < QUEUE_DEPTH;
    assign accept     = i_s_tvalid && o_s_tready;

    // Classify the item and advance the packet state
    always_comb begin
        n_sending      = r_sending;
        n_next_index   = r_next_index;
        n_send_length  = r_send_length;
        n_retry_count  = r_retry_count;
        n_mouse_target = r_mouse_target;
        cmd_push       = 1'b0;
        cmd            = '0;
        rd_idx         = '0;
        ram_we         = 1'b0;
        idx_v          = r_next_index;
        retry_v        = r_retry_count;
        stop_v         = 1'b0;
        if (accept) begin
            unique case (f_mode)
                MODE_LOAD: begin
                    ram_we = int'(f_idx) < MAX_PACKET_BYTES;
                end
                MODE_START: begin
                    cmd_push = 1'b1;
                    if (r_sending) begin
                        cmd.finished = 1'b1;
                        cmd.status   = ST_BUSY;
                    end else begin
                        n_mouse_target = f_mouse;
                        n_send_length  = (int'(f_cnt) > MAX_PACKET_BYTES) ?
                                         CNT_W'(MAX_PACKET_BYTES) : f_cnt;
                        n_next_index   = '0;
                        if (f_ready) begin
                            cmd.send     = 1'b1;
                            cmd.mouse    = f_mouse;
                            cmd.status   = ST_PENDING;
                            n_next_index = CNT_W'(1);
                            n_sending    = 1'b1;
                        end else begin
                            cmd.finished = 1'b1;
                            cmd.status   = ST_TIMEOUT;
                        end
                    end
                end
                MODE_REPLY: begin
                    cmd_push = 1'b1;
                    if (r_sending) begin
                        cmd.handled = 1'b1;
                        // Resend backs up one byte, nack fails, anything else moves on
                        if (f_val == REPLY_RESEND) begin
                            if (r_retry_count >= r_resend_limit) begin
                                cmd.finished  = 1'b1;
                                cmd.status    = ST_TIMEOUT;
                                n_sending     = 1'b0;
                                n_retry_count = '0;
                                stop_v        = 1'b1;
                            end else begin
                                retry_v = r_retry_count + 8'd1;
                                if (r_next_index != '0) begin
                                    idx_v = r_next_index - CNT_W'(1);
                                end
                            end
                        end else if (f_val == REPLY_NACK) begin
                            cmd.finished  = 1'b1;
                            cmd.status    = ST_REFUSED;
                            n_sending     = 1'b0;
                            n_retry_count = '0;
                            stop_v        = 1'b1;
                        end else begin
                            retry_v = '0;
                        end
                        if (!stop_v) begin
                            n_retry_count = retry_v;
                            n_next_index  = idx_v;
                            if (idx_v >= r_send_length) begin
                                cmd.finished = 1'b1;
                                cmd.status   = ST_SUCCESS;
                                n_sending    = 1'b0;
                            end else if (f_ready) begin
                                cmd.send     = 1'b1;
                                cmd.mouse    = r_mouse_target;
                                cmd.status   = ST_PENDING;
                                rd_idx       = idx_v;
                                n_next_index = idx_v + CNT_W'(1);
                            end else begin
                                cmd.finished = 1'b1;
                                cmd.status   = ST_TIMEOUT;
                                n_sending    = 1'b0;
                            end
                        end
                    end else begin
                        cmd.status = ST_PENDING;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Fit store addresses to the store depth
    assign rd_wide = (AW + CNT_W)'(rd_idx);
    assign wr_wide = (AW + IDX_W)'(f_idx);

    ps2cps_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PACKET_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_wide[AW-1:0]),
        .i_wdata (f_val),
        .i_raddr (rd_wide[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Hold state, resend limit and the fetch stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending      <= 1'b0;
            r_next_index   <= '0;
            r_send_length  <= '0;
            r_retry_count  <= '0;
            r_mouse_target <= 1'b0;
            r_resend_limit <= RESEND_LIMIT_RST;
            r_s1_valid     <= 1'b0;
        end else begin
            r_sending      <= n_sending;
            r_next_index   <= n_next_index;
            r_send_length  <= n_send_length;
            r_retry_count  <= n_retry_count;
            r_mouse_target <= n_mouse_target;
            r_s1_valid     <= cmd_push;
            if (i_cfg_valid) begin
                r_resend_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd <= cmd;
    end

    // Push the command together with the fetched byte
    assign o_q_push       = r_s1_valid;
    assign o_q_entry.cmd  = r_s1_cmd;
    assign o_q_entry.data = ram_rdata;

    // A push never lands in a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (int'(i_q_count) < QUEUE_DEPTH))
        else $error("front pushes into a full queue");

    // Sending begins only through an accepted start item
    a_send_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sending) |-> $past(accept && (f_mode == MODE_START)))
        else $error("sending began without a start item");

endmodule

FILE: rtl/core/ps2cps_queue.sv
// Short command queue between the front and back end.
module ps2cps_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  ps2cps_pkg::t_qentry             i_entry,
    input  logic                            i_pop,
    output ps2cps_pkg::t_qentry             o_entry,
    output logic                            o_empty,
    output logic [ps2cps_pkg::QUEUE_CW-1:0] o_count
);
    import ps2cps_pkg::*;

    t_qentry             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_CW-1:0] r_count;

    // Advance pointers and count; pointers wrap at the power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (int'(r_count) < QUEUE_DEPTH) || i_pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");

endmodule

FILE: rtl/core/ps2cps_back.sv
// Back end: expands queued commands into controller writes and status reports.
module ps2cps_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  ps2cps_pkg::t_qentry              i_q_entry,
    output logic                             o_q_pop,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ps2cps_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);
    import ps2cps_pkg::*;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_DATA   = 3'b010,
        PH_STATUS = 3'b100
    } t_phase;

    logic              r_busy, n_busy;
    t_phase            r_phase, n_phase;
    t_cmd              r_cmd, n_cmd;
    logic [BYTE_W-1:0] r_data, n_data;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [M_FIELD_W-1:0] r_out_fields, n_out_fields;
    logic                 r_out_kind, n_out_kind;
    logic                 r_out_last, n_out_last;

    logic slot_free;
    logic emit;
    logic done;

    assign slot_free = !r_out_valid || i_m_tready;

    // Emit one result per free slot, then take the next command
    always_comb begin
        n_busy       = r_busy;
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_data       = r_data;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_fields = r_out_fields;
        n_out_kind   = r_out_kind;
        n_out_last   = r_out_last;
        o_q_pop      = 1'b0;
        emit         = r_busy && slot_free;
        done         = 1'b0;
        if (emit) begin
            n_out_valid = 1'b1;
            unique case (r_phase)
                PH_PREFIX: begin
                    n_out_kind   = 1'b0;
                    n_out_last   = 1'b0;
                    n_out_fields = {STATUS_W'(0), 1'b0, 1'b0, PREFIX_MOUSE, 1'b1};
                    n_phase      = PH_DATA;
                end
                PH_DATA: begin
                    n_out_kind   = 1'b0;
                    n_out_last   = 1'b0;
                    n_out_fields = {STATUS_W'(0), 1'b0, 1'b0, r_data, 1'b0};
                    n_phase      = PH_STATUS;
                end
                PH_STATUS: begin
                    n_out_kind   = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_fields = {r_cmd.status, r_cmd.finished, r_cmd.handled,
                                    BYTE_W'(0), 1'b0};
                    done         = 1'b1;
                end
                default: begin
                    n_phase = PH_STATUS;
                end
            endcase
        end
        if (!r_busy || done) begin
            n_busy = !i_q_empty;
            if (!i_q_empty) begin
                o_q_pop = 1'b1;
                n_cmd   = i_q_entry.cmd;
                n_data  = i_q_entry.data;
                if (!i_q_entry.cmd.send) begin
                    n_phase = PH_STATUS;
                end else if (i_q_entry.cmd.mouse) begin
                    n_phase = PH_PREFIX;
                end else begin
                    n_phase = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_STATUS;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_data       <= n_data;
        r_out_fields <= n_out_fields;
        r_out_kind   <= n_out_kind;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_fields);
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: test/ps2_command_packet_sender_tb.sv
// Testbench for the PS/2 command packet sender: directed table, then random packets.
`timescale 1ns / 1ps

module ps2_command_packet_sender_tb;
    import ps2cps_pkg::*;

    localparam int STORE_DEPTH    = MAX_PACKET_BYTES_DEF;
    localparam int PHASE_ITEMS    = 12;
    localparam int IDLE_PCT       = 26;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One input item, fields as the block sees them
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] idx;
        logic [7:0] val;
        logic [4:0] cnt;
        logic       mouse;
        logic       ready;
    } t_item;

    // One result of the block
    typedef struct packed {
        logic          kind;
        logic          ctrl;
        logic [7:0]    value;
        logic          handled;
        logic          fin;
        logic [2:0]    status;
        logic          last;
    } t_result;

    // Directed row: item plus an optional typed-in status report
    typedef struct packed {
        t_item      item;
        logic       typed;
        logic       handled;
        logic       fin;
        logic [2:0] status;
    } t_steer_row;

    localparam t_steer_row STEER [24] = '{
        // reply right after reset: not consumed
        '{'{MODE_REPLY, 4'd0, 8'h00, 5'd0, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0, ST_PENDING},
        // start with controller not ready, largest count
        '{'{MODE_START, 4'hF, 8'hFF, 5'd31, 1'b1, 1'b0}, 1'b1, 1'b0, 1'b1, ST_TIMEOUT},
        // unused mode, all ones
        '{'{MODE_UNUSED, 4'hF, 8'hFF, 5'd31, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_LOAD, 4'd0, 8'h00, 5'd0, 1'b0, 1'b0}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_LOAD, 4'd1, 8'hFF, 5'd31, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_LOAD, 4'd2, 8'h5A, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_LOAD, 4'd15, 8'hA5, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_START, 4'd0, 8'h00, 5'd3, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        // start while a packet is in flight
        '{'{MODE_START, 4'd0, 8'h00, 5'd5, 1'b1, 1'b1}, 1'b1, 1'b0, 1'b1, ST_BUSY},
        // resends up to the limit, then one too many
        '{'{MODE_REPLY, 4'd0, REPLY_RESEND, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, REPLY_RESEND, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, REPLY_RESEND, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, REPLY_RESEND, 5'd0, 1'b0, 1'b1}, 1'b1, 1'b1, 1'b1, ST_TIMEOUT},
        // zero count to the mouse; a resend backs up to index zero and ends it
        '{'{MODE_START, 4'd0, 8'h00, 5'd0, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, REPLY_RESEND, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_START, 4'd0, 8'h00, 5'd3, 1'b1, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, 8'hFA, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        // controller stops accepting mid-packet
        '{'{MODE_REPLY, 4'd0, 8'hFA, 5'd0, 1'b0, 1'b0}, 1'b1, 1'b1, 1'b1, ST_TIMEOUT},
        '{'{MODE_START, 4'd0, 8'h00, 5'd2, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        // device refuses
        '{'{MODE_REPLY, 4'd0, REPLY_NACK, 5'd0, 1'b0, 1'b1}, 1'b1, 1'b1, 1'b1, ST_REFUSED},
        '{'{MODE_START, 4'd0, 8'h00, 5'd2, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, 8'h00, 5'd0, 1'b0, 1'b1}, 1'b0, 1'b0, 1'b0, ST_PENDING},
        '{'{MODE_REPLY, 4'd0, 8'hFF, 5'd0, 1'b0, 1'b1}, 1'b1, 1'b1, 1'b1, ST_SUCCESS},
        // resend while idle is not consumed
        '{'{MODE_REPLY, 4'd0, REPLY_RESEND, 5'd0, 1'b0, 1'b1}, 1'b1, 1'b0, 1'b0, ST_PENDING}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TUSER_W-1:0] i_s_tuser;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [BYTE_W-1:0]    i_cfg_data;

    ps2_command_packet_sender dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted sender state
    logic [7:0] byte_store [STORE_DEPTH];
    bit         loaded [STORE_DEPTH];
    logic [4:0] cursor;
    logic [4:0] length;
    bit         in_flight;
    logic [7:0] retries;
    bit         mouse_dev;
    logic [7:0] resend_limit;

    t_result pending_results [$];
    t_result fresh [$];

    int  mismatches;
    int  items_done;
    int  stall_cycles;
    bit  calm;
    bit  hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void note_write(logic ctrl, logic [7:0] v);
        fresh.push_back('{KIND_WRITE, ctrl, v, 1'b0, 1'b0, ST_PENDING, 1'b0});
    endfunction

    function automatic void note_status(logic h, logic f, logic [2:0] st);
        fresh.push_back('{KIND_STATUS, 1'b0, 8'h00, h, f, st, 1'b1});
    endfunction

    // Write the current packet byte, behind the prefix for the mouse
    function automatic void write_current();
        if (mouse_dev) note_write(1'b1, PREFIX_MOUSE);
        note_write(1'b0, byte_store[cursor[3:0]]);
    endfunction

    // Advance the predicted state by one item and collect its results in fresh
    function automatic void predict_packet_step(t_item it);
        case (it.mode)
            MODE_LOAD: begin
                byte_store[it.idx] = it.val;
                loaded[it.idx]     = 1'b1;
            end
            MODE_START: begin
                if (in_flight) begin
                    note_status(1'b0, 1'b1, ST_BUSY);
                end else begin
                    mouse_dev = it.mouse;
                    length    = (it.cnt > 5'(STORE_DEPTH)) ? 5'(STORE_DEPTH) : it.cnt;
                    cursor    = 5'd0;
                    if (!it.ready) begin
                        note_status(1'b0, 1'b1, ST_TIMEOUT);
                    end else begin
                        write_current();
                        cursor    = cursor + 5'd1;
                        in_flight = 1'b1;
                        note_status(1'b0, 1'b0, ST_PENDING);
                    end
                end
            end
            MODE_REPLY: begin
                if (!in_flight) begin
                    note_status(1'b0, 1'b0, ST_PENDING);
                end else if (it.val == REPLY_RESEND && retries >= resend_limit) begin
                    in_flight = 1'b0;
                    retries   = 8'd0;
                    note_status(1'b1, 1'b1, ST_TIMEOUT);
                end else if (it.val == REPLY_NACK) begin
                    in_flight = 1'b0;
                    retries   = 8'd0;
                    note_status(1'b1, 1'b1, ST_REFUSED);
                end else begin
                    if (it.val == REPLY_RESEND) begin
                        retries = retries + 8'd1;
                        if (cursor != 5'd0) cursor = cursor - 5'd1;
                    end else begin
                        retries = 8'd0;
                    end
                    if (cursor >= length) begin
                        in_flight = 1'b0;
                        note_status(1'b1, 1'b1, ST_SUCCESS);
                    end else if (!it.ready) begin
                        in_flight = 1'b0;
                        note_status(1'b1, 1'b1, ST_TIMEOUT);
                    end else begin
                        write_current();
                        cursor = cursor + 5'd1;
                        note_status(1'b1, 1'b0, ST_PENDING);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Number of store entries loaded from index zero without a hole
    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < STORE_DEPTH && loaded[n]) n++;
        return n;
    endfunction

    function automatic t_item random_fields();
        t_item it;
        it.mode  = 2'($urandom_range(0, 3));
        it.idx   = 4'($urandom_range(0, 15));
        it.val   = 8'($urandom_range(0, 255));
        it.cnt   = 5'($urandom_range(0, 31));
        it.mouse = 1'($urandom_range(0, 1));
        it.ready = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one item, wait for its transfer, then record what it should produce
    task automatic offer(input t_item it, input bit typed = 1'b0,
                         input t_result typed_res = '0);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.mode;
        i_s_tdata  <= {5'b0, it.ready, it.mouse, it.cnt, it.val, it.idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        fresh.delete();
        predict_packet_step(it);
        if (typed) pending_results.push_back(typed_res);
        else foreach (fresh[k]) pending_results.push_back(fresh[k]);
        if (it.mode != MODE_UNUSED) items_done++;
        @(negedge i_clk);
    endtask

    // Drop the input and wait until every predicted result has arrived
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_resend_limit(input logic [7:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        resend_limit = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_reply();
        t_item it;
        int    pick;
        it      = random_fields();
        it.mode = MODE_REPLY;
        pick    = $urandom_range(0, 99);
        if (pick < 5) begin
            it.val = REPLY_NACK;
        end else if (pick < 27) begin
            it.val = REPLY_RESEND;
        end else begin
            do it.val = 8'($urandom_range(0, 255));
            while (it.val == REPLY_RESEND || it.val == REPLY_NACK);
        end
        it.ready = ($urandom_range(0, 99) >= 4);
        offer(it);
    endtask

    // Load a packet, start it and answer until it ends or is abandoned
    task automatic run_packet();
        t_item it;
        int    len;
        int    pick;
        int    p;
        int    replies;
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 4);
        else if (pick < 90) len = $urandom_range(5, 15);
        else len = STORE_DEPTH;
        for (int i = 0; i < len; i++) begin
            it      = random_fields();
            it.mode = MODE_LOAD;
            it.idx  = 4'(i);
            offer(it);
        end
        p        = loaded_prefix();
        it       = random_fields();
        it.mode  = MODE_START;
        it.ready = ($urandom_range(0, 99) >= 8);
        pick     = $urandom_range(0, 99);
        if (p == STORE_DEPTH && pick < 20) it.cnt = 5'($urandom_range(16, 31));
        else if (pick < 75) it.cnt = 5'(len);
        else it.cnt = 5'($urandom_range(0, p));
        offer(it);
        replies = 0;
        while (in_flight && replies < 40 && $urandom_range(0, 99) >= 3) begin
            random_reply();
            replies++;
        end
    endtask

    // Single stray item: load anywhere, stray reply, start or unused mode
    task automatic random_noise();
        t_item it;
        int    pick;
        int    need;
        it   = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.mode = MODE_LOAD;
        end else if (pick < 50) begin
            it.mode = MODE_REPLY;
        end else if (pick < 75) begin
            it.mode = MODE_START;
            // keep an idle start from sending an entry never loaded
            need = (it.cnt > 5'(STORE_DEPTH)) ? STORE_DEPTH : int'(it.cnt);
            if (need == 0) need = 1;
            if (!in_flight && loaded_prefix() < need) it.ready = 1'b0;
        end else begin
            it.mode = MODE_UNUSED;
        end
        offer(it);
    endtask

    task automatic run_phase();
        int first;
        first = items_done;
        while (items_done - first < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 80) run_packet();
            else random_noise();
        end
    endtask

    // Main stimulus
    initial begin
        t_result report;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = '0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        mismatches  = 0;
        items_done  = 0;
        cursor      = 5'd0;
        length      = 5'd0;
        in_flight   = 1'b0;
        retries     = 8'd0;
        mouse_dev   = 1'b0;
        resend_limit = RESEND_LIMIT_RST;
        foreach (loaded[k]) begin
            loaded[k]     = 1'b0;
            byte_store[k] = 8'h00;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (STEER[i]) begin
            report = '{KIND_STATUS, 1'b0, 8'h00, STEER[i].handled, STEER[i].fin,
                       STEER[i].status, 1'b1};
            offer(STEER[i].item, STEER[i].typed, report);
        end

        set_resend_limit(8'd0);
        run_phase();

        // long stretch without idling; the receiver holds off at its start
        set_resend_limit(8'd255);
        calm     = 1'b1;
        hold_req = 1'b1;
        run_phase();
        settle();
        run_phase();
        calm = 1'b0;

        set_resend_limit(8'd1);
        run_phase();
        set_resend_limit(8'($urandom_range(2, 6)));
        run_phase();

        settle();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: random back-pressure, or one long hold when asked
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata %h tuser %b tlast %b",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_m_tuser));
                check_field("to_control_port", 8'(want.ctrl), 8'(o_m_tdata[0]));
                check_field("write_value", want.value, o_m_tdata[8:1]);
                check_field("handled", 8'(want.handled), 8'(o_m_tdata[9]));
                check_field("finished", 8'(want.fin), 8'(o_m_tdata[10]));
                check_field("status", 8'(want.status), 8'(o_m_tdata[13:11]));
                check_field("last", 8'(want.last), 8'(o_m_tlast));
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

FILE: files.f
rtl/core/ps2cps_pkg.sv
rtl/core/ps2cps_ram.sv
rtl/core/ps2cps_front.sv
rtl/core/ps2cps_queue.sv
rtl/core/ps2cps_back.sv
rtl/core/ps2_command_packet_sender.sv
test/ps2_command_packet_sender_tb.sv
